>>> design/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg: shared types and constants for the sorted date table
// command and status codes, table sizing and the result record
// ----------------------------------------------------------------------------
package sdt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int DATE_W      = 21;
    localparam int POS_W       = 6;
    localparam int COUNT_OUT_W = 7;
    localparam int IDX_W       = 6;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INSERTED  = 4'd0,
        ST_DUPLICATE = 4'd1,
        ST_REMOVED   = 4'd2,
        ST_NOT_FOUND = 4'd3,
        ST_EMPTY     = 4'd4,
        ST_FULL      = 4'd5,
        ST_FOUND     = 4'd6,
        ST_READ_OK   = 4'd7,
        ST_BAD_INDEX = 4'd8
    } status_t;

    // date word: year [20:9], month [8:5], day [4:0]
    typedef struct packed {
        status_t                  status;
        logic [POS_W-1:0]         position;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic [DATE_W-1:0]        date;
    } res_t;

endpackage

>>> design/sdt_ram.sv
// ----------------------------------------------------------------------------
// sdt_ram: simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sdt_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 21,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/sdt_seq.sv
// ----------------------------------------------------------------------------
// sdt_seq: command sequencer for the sorted date table
// linear scan with one shared comparator, then an entry-by-entry shift
// ----------------------------------------------------------------------------
module sdt_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    // command side
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  sdt_pkg::cmd_t               cmd_in,
    input  logic [sdt_pkg::DATE_W-1:0]  key_in,
    input  logic [sdt_pkg::IDX_W-1:0]   idx_in,
    // result side
    output logic                        res_valid,
    input  logic                        res_ready,
    output sdt_pkg::res_t               res_out,
    // table ram
    output logic                        wr_en,
    output logic [sdt_pkg::ADDR_W-1:0]  wr_addr,
    output logic [sdt_pkg::DATE_W-1:0]  wr_data,
    output logic                        rd_en,
    output logic [sdt_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [sdt_pkg::DATE_W-1:0]  rd_data
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_SCAN_RD   = 7'b0000010,
        S_SCAN_CMP  = 7'b0000100,
        S_SHIFT_RD  = 7'b0001000,
        S_SHIFT_WR  = 7'b0010000,
        S_READ_WAIT = 7'b0100000,
        S_DONE      = 7'b1000000
    } state_t;

    localparam int CW = sdt_pkg::CNT_W;
    localparam int AW = sdt_pkg::ADDR_W;

    state_t                       state_reg, state_next;
    sdt_pkg::cmd_t                cmd_reg, cmd_next;
    logic [sdt_pkg::DATE_W-1:0]   key_reg, key_next;
    logic [sdt_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic [CW-1:0]                count_reg, count_next;
    sdt_pkg::res_t                res_reg, res_next;

    logic cmp_ge;
    logic cmp_eq;
    logic resolve;
    logic match;

    function automatic sdt_pkg::res_t make_res(
        input sdt_pkg::status_t           st,
        input logic [31:0]                pos,
        input logic [31:0]                cnt,
        input logic [sdt_pkg::DATE_W-1:0] date
    );
        sdt_pkg::res_t r;
        r.status      = st;
        r.position    = pos[sdt_pkg::POS_W-1:0];
        r.entry_count = cnt[sdt_pkg::COUNT_OUT_W-1:0];
        r.date        = date;
        return r;
    endfunction

    // shared compare unit: stored entry against the key
    assign cmp_ge = (rd_data >= key_reg);
    assign cmp_eq = (rd_data == key_reg);

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = ptr_reg[AW-1:0];
        wr_data    = key_reg;
        resolve    = 1'b0;
        match      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next = cmd_in;
                    key_next = key_in;
                    idx_next = idx_in;
                    ptr_next = '0;
                    unique case (cmd_in)
                        sdt_pkg::CMD_INSERT: begin
                            if (32'(count_reg) >= sdt_pkg::TABLE_DEPTH) begin
                                res_next = make_res(sdt_pkg::ST_FULL, 32'd0,
                                                    32'(count_reg), key_in);
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        sdt_pkg::CMD_REMOVE: begin
                            if (count_reg == '0) begin
                                res_next = make_res(sdt_pkg::ST_EMPTY, 32'd0,
                                                    32'(count_reg), key_in);
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        sdt_pkg::CMD_FIND: begin
                            state_next = S_SCAN_RD;
                        end
                        sdt_pkg::CMD_READ: begin
                            if (count_reg == '0) begin
                                res_next = make_res(sdt_pkg::ST_EMPTY, 32'(idx_in),
                                                    32'(count_reg), '0);
                                state_next = S_DONE;
                            end else if (32'(idx_in) >= 32'(count_reg)) begin
                                res_next = make_res(sdt_pkg::ST_BAD_INDEX, 32'(idx_in),
                                                    32'(count_reg), '0);
                                state_next = S_DONE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(idx_in);
                                state_next = S_READ_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ_WAIT: begin
                res_next = make_res(sdt_pkg::ST_READ_OK, 32'(idx_reg),
                                    32'(count_reg), rd_data);
                state_next = S_DONE;
            end
            S_SCAN_RD: begin
                if (ptr_reg == count_reg) begin
                    // ran off the end: key is above every entry
                    resolve = 1'b1;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (cmp_ge) begin
                    resolve = 1'b1;
                    match   = cmp_eq;
                end else begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (cmd_reg == sdt_pkg::CMD_INSERT) begin
                    if (ptr_reg == pos_reg) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        res_next   = make_res(sdt_pkg::ST_INSERTED, 32'(pos_reg),
                                              32'(count_reg) + 32'd1, key_reg);
                        state_next = S_DONE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(ptr_reg - 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                end else begin
                    if (CW'(ptr_reg + 1'b1) == count_reg) begin
                        count_next = count_reg - 1'b1;
                        res_next   = make_res(sdt_pkg::ST_REMOVED, 32'(pos_reg),
                                              32'(count_reg) - 32'd1, key_reg);
                        state_next = S_DONE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(ptr_reg + 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                if (cmd_reg == sdt_pkg::CMD_INSERT) begin
                    ptr_next = ptr_reg - 1'b1;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
                state_next = S_SHIFT_RD;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (resolve) begin
            pos_next = ptr_reg;
            case (cmd_reg)
                sdt_pkg::CMD_INSERT: begin
                    if (match) begin
                        res_next = make_res(sdt_pkg::ST_DUPLICATE, 32'(ptr_reg),
                                            32'(count_reg), key_reg);
                        state_next = S_DONE;
                    end else begin
                        ptr_next   = count_reg;
                        state_next = S_SHIFT_RD;
                    end
                end
                sdt_pkg::CMD_REMOVE: begin
                    if (match) begin
                        state_next = S_SHIFT_RD;
                    end else begin
                        res_next = make_res(sdt_pkg::ST_NOT_FOUND, 32'd0,
                                            32'(count_reg), key_reg);
                        state_next = S_DONE;
                    end
                end
                default: begin
                    if (match) begin
                        res_next = make_res(sdt_pkg::ST_FOUND, 32'(ptr_reg),
                                            32'(count_reg), key_reg);
                    end else begin
                        res_next = make_res(sdt_pkg::ST_NOT_FOUND, 32'd0,
                                            32'(count_reg), key_reg);
                    end
                    state_next = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
        ptr_reg <= ptr_next;
        pos_reg <= pos_next;
        res_reg <= res_next;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_out   = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= sdt_pkg::TABLE_DEPTH)
        else $error("entry count above table depth");

    a_write_in_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_SHIFT_RD || state_reg == S_SHIFT_WR))
        else $error("table written outside a shift");

    a_count_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> (state_reg == S_DONE))
        else $error("entry count changed mid-command");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN_CMP) |-> (ptr_reg < count_reg))
        else $error("scan compared an entry beyond the count");

endmodule

>>> design/sorted_date_table.sv
// ----------------------------------------------------------------------------
// sorted_date_table: sorted table of distinct dates
// insert, remove, find and indexed read over a table kept in ascending order
// ----------------------------------------------------------------------------
// usage
//   s_ channel takes one command beat: insert, remove, find or read at index
//   m_ channel gives exactly one result beat per command: status, position,
//   entry count after the command and the date concerned
//   dates are ordered by year, then month, then day; no date validation
// command flow
//   one command at a time; s_tready is high only while the sequencer is idle
//   a scan goes entry by entry up to the key's place (one ram read, then one
//   compare in the shared comparator per entry), and an insert or remove
//   moves the shifted entries one by one (a ram read, then a ram write);
//   the table ram's single read port and its registered read set that order
// reset
//   aresetn low empties the table (count to zero) and drops m_tvalid
// stall
//   results sit in an output register; a stalled m_ side holds the beat and
//   the sequencer waits with the next result until that register frees up
// ----------------------------------------------------------------------------
module sorted_date_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd [1:0], day [6:2], month [10:7], year [22:11], index [28:23]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status [3:0], position [9:4], entry_count [16:10], out_day [21:17],
    // out_month [25:22], out_year [37:26]
    output logic [39:0] m_tdata
);

    logic                        cmd_ready;
    sdt_pkg::cmd_t               cmd_in;
    logic [sdt_pkg::DATE_W-1:0]  key_in;
    logic [sdt_pkg::IDX_W-1:0]   idx_in;

    logic                        res_valid;
    logic                        res_ready;
    sdt_pkg::res_t               res;

    logic                        wr_en;
    logic [sdt_pkg::ADDR_W-1:0]  wr_addr;
    logic [sdt_pkg::DATE_W-1:0]  wr_data;
    logic                        rd_en;
    logic [sdt_pkg::ADDR_W-1:0]  rd_addr;
    logic [sdt_pkg::DATE_W-1:0]  rd_data;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [39:0]                 m_tdata_reg, m_tdata_next;

    // day, month and year sit in the beat already in sort-key order
    assign cmd_in   = sdt_pkg::cmd_t'(s_tdata[1:0]);
    assign key_in   = s_tdata[22:2];
    assign idx_in   = s_tdata[28:23];
    assign s_tready = cmd_ready;

    sdt_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (cmd_ready),
        .cmd_in    (cmd_in),
        .key_in    (key_in),
        .idx_in    (idx_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_out   (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    sdt_ram #(
        .DEPTH  (sdt_pkg::TABLE_DEPTH),
        .WIDTH  (sdt_pkg::DATE_W),
        .ADDR_W (sdt_pkg::ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, res.date, res.entry_count, res.position, res.status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression for sorted_date_table
// drives insert, remove, find and indexed read commands over the stream
// ports, keeps its own copy of the sorted table to predict every result beat,
// and compares each result field by field while both sides idle at random
// ----------------------------------------------------------------------------
module testbench;

    import sdt_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    // the limit covers the slowest commands, a full-table scan and shift, plus
    // short random stalls on both sides, several times over for ~1000 commands
    localparam int LIMIT_TIME   = 8_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int IDLE_PCT     = 38;

    // ------------------------------------------------------------------------
    // tracker: mirror of the sorted table and the queue of awaited results
    // ------------------------------------------------------------------------
    class date_table_tracker;
        logic [DATE_W-1:0] dates [TABLE_DEPTH];
        int                held;
        res_t              pending_outcomes [$];
        int                tally [9];
        int                commands;
        int                mismatches;

        function new();
            held = 0;
            commands = 0;
            mismatches = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function int held_count();
            return held;
        endfunction

        function logic [DATE_W-1:0] held_date(int pos);
            return dates[pos];
        endfunction

        function int pending_count();
            return pending_outcomes.size();
        endfunction

        // applies one command to the mirror and gives the result it causes
        function res_t table_outcome(cmd_t cmd, logic [DATE_W-1:0] key,
                                     logic [IDX_W-1:0] idx);
            res_t r;
            int   hit;
            int   pos;
            int   i;
            hit = -1;
            for (i = 0; i < held; i++)
                if (hit < 0 && dates[i] == key) hit = i;
            r.position = '0;
            r.date = key;
            case (cmd)
                CMD_INSERT: begin
                    // a full table wins over a duplicate
                    if (held >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else if (hit >= 0) begin
                        r.status = ST_DUPLICATE;
                        r.position = POS_W'(hit);
                        r.date = dates[hit];
                    end else begin
                        pos = 0;
                        while (pos < held && dates[pos] < key) pos++;
                        for (i = held; i > pos; i--) dates[i] = dates[i-1];
                        dates[pos] = key;
                        held++;
                        r.status = ST_INSERTED;
                        r.position = POS_W'(pos);
                    end
                end
                CMD_REMOVE: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        for (i = hit; i + 1 < held; i++) dates[i] = dates[i+1];
                        held--;
                        r.status = ST_REMOVED;
                        r.position = POS_W'(hit);
                    end
                end
                CMD_FIND: begin
                    if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.status = ST_FOUND;
                        r.position = POS_W'(hit);
                        r.date = dates[hit];
                    end
                end
                default: begin
                    r.position = idx;
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                        r.date = '0;
                    end else if (int'(idx) >= held) begin
                        r.status = ST_BAD_INDEX;
                        r.date = '0;
                    end else begin
                        r.status = ST_READ_OK;
                        r.date = dates[idx];
                    end
                end
            endcase
            r.entry_count = COUNT_OUT_W'(held);
            return r;
        endfunction

        function void note_command(cmd_t cmd, logic [DATE_W-1:0] key,
                                   logic [IDX_W-1:0] idx);
            res_t r;
            r = table_outcome(cmd, key, idx);
            tally[int'(r.status)]++;
            commands++;
            pending_outcomes.push_back(r);
        endfunction

        task report_mismatch(string what);
            // keep the log short if the block is badly broken
            if (mismatches < 200) $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_result(logic [39:0] beat);
            res_t want;
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("result beat %h with nothing awaited", beat));
                return;
            end
            want = pending_outcomes.pop_front();
            if (beat[3:0] !== want.status)
                report_mismatch($sformatf("status %h, awaited %s", beat[3:0],
                                          want.status.name()));
            if (beat[9:4] !== want.position)
                report_mismatch($sformatf("position %0d, awaited %0d", beat[9:4],
                                          want.position));
            if (beat[16:10] !== want.entry_count)
                report_mismatch($sformatf("entry count %0d, awaited %0d", beat[16:10],
                                          want.entry_count));
            if (beat[21:17] !== want.date[4:0])
                report_mismatch($sformatf("day %0d, awaited %0d", beat[21:17],
                                          want.date[4:0]));
            if (beat[25:22] !== want.date[8:5])
                report_mismatch($sformatf("month %0d, awaited %0d", beat[25:22],
                                          want.date[8:5]));
            if (beat[37:26] !== want.date[20:9])
                report_mismatch($sformatf("year %0d, awaited %0d", beat[37:26],
                                          want.date[20:9]));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // cmd [1:0], day [6:2], month [10:7], year [22:11], index [28:23]
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status [3:0], position [9:4], entry_count [16:10], out_day [21:17],
    // out_month [25:22], out_year [37:26]
    logic [39:0] m_tdata;

    // random idling on both sides, switched off for one long stretch
    logic        idle_on  = 1'b1;

    date_table_tracker tracker = new();

    always #2 aclk = ~aclk;

    sorted_date_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // result side: values read here are the ones from before the edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
        m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_TIME);
        $display("sorted_date_table regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [DATE_W-1:0] mk_date(int day, int month, int year);
        return {12'(year), 4'(month), 5'(day)};
    endfunction

    function automatic logic [DATE_W-1:0] rand_date();
        return DATE_W'($urandom);
    endfunction

    // one command beat; the date word lines up with day, month and year
    // in s_tdata, so the beat is a plain concatenation
    task automatic send_command(cmd_t cmd, logic [DATE_W-1:0] key,
                                logic [IDX_W-1:0] idx);
        if (idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, idx, key, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_command(cmd, key, idx);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [DATE_W-1:0] small_pool [12];
        logic [DATE_W-1:0] key;
        logic [IDX_W-1:0]  idx;
        cmd_t              cmd;
        int                held;
        int                roll;
        int                n;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: empty table first, then the date extremes and ordering
        send_command(CMD_READ,   mk_date(0, 0, 0), 6'd63);       // read on empty
        send_command(CMD_REMOVE, mk_date(5, 5, 5), 6'd0);        // remove on empty
        send_command(CMD_FIND,   mk_date(5, 5, 5), 6'd0);        // find on empty
        send_command(CMD_INSERT, mk_date(0, 0, 0), 6'd0);        // lowest date
        send_command(CMD_INSERT, mk_date(31, 15, 4095), 6'd0);   // highest date
        send_command(CMD_INSERT, mk_date(0, 0, 0), 6'd0);        // duplicate
        send_command(CMD_INSERT, mk_date(15, 6, 2024), 6'd0);
        send_command(CMD_INSERT, mk_date(1, 6, 2024), 6'd0);     // day decides
        send_command(CMD_INSERT, mk_date(20, 7, 2023), 6'd0);    // year decides
        send_command(CMD_INSERT, mk_date(15, 5, 2024), 6'd0);    // month decides
        send_command(CMD_INSERT, mk_date(31, 15, 4095), 6'd0);   // duplicate at the end
        send_command(CMD_FIND,   mk_date(31, 15, 4095), 6'd0);   // found
        send_command(CMD_FIND,   mk_date(2, 2, 2), 6'd0);        // not found
        send_command(CMD_READ,   mk_date(0, 0, 0), 6'd0);        // first entry
        send_command(CMD_READ,   mk_date(0, 0, 0), 6'd5);        // last entry
        send_command(CMD_READ,   mk_date(0, 0, 0), 6'd6);        // index at count
        send_command(CMD_READ,   mk_date(0, 0, 0), 6'd63);       // far beyond count
        send_command(CMD_REMOVE, mk_date(15, 6, 2024), 6'd0);    // removed mid table
        send_command(CMD_REMOVE, mk_date(15, 6, 2024), 6'd0);    // now not found
        send_command(CMD_REMOVE, mk_date(0, 0, 0), 6'd0);        // first entry
        send_command(CMD_REMOVE, mk_date(31, 15, 4095), 6'd0);   // last entry
        send_command(CMD_READ,   mk_date(0, 0, 0), 6'd2);

        foreach (small_pool[i]) small_pool[i] = rand_date();

        // random: small key pool, then fill to full and sit there, then drain
        // to empty, then unconstrained noise
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on <= !(n >= 100 && n < 250);
            held = tracker.held_count();
            roll = $urandom_range(99);
            if (n < 250) begin
                // few keys, so duplicates, finds and removes hit often
                cmd = cmd_t'($urandom_range(3));
                key = small_pool[$urandom_range(11)];
                idx = IDX_W'($urandom_range(15));
            end else if (n < 600) begin
                if (held < TABLE_DEPTH) begin
                    cmd = (roll < 80) ? CMD_INSERT : cmd_t'($urandom_range(3));
                end else if (roll < 45) begin
                    cmd = CMD_INSERT;
                end else if (roll < 75) begin
                    cmd = CMD_READ;
                end else if (roll < 90) begin
                    cmd = CMD_FIND;
                end else begin
                    cmd = CMD_REMOVE;
                end
                if (held > 0 && $urandom_range(3) == 0)
                    key = tracker.held_date($urandom_range(held - 1));
                else
                    key = rand_date();
                idx = IDX_W'($urandom_range(63));
            end else if (n < 800) begin
                if (roll < 70) begin
                    cmd = CMD_REMOVE;
                    key = (held > 0) ? tracker.held_date($urandom_range(held - 1))
                                     : rand_date();
                end else begin
                    cmd = cmd_t'($urandom_range(3));
                    key = (held > 0 && roll < 85)
                        ? tracker.held_date($urandom_range(held - 1)) : rand_date();
                end
                idx = (held > 0) ? IDX_W'($urandom_range(held)) : IDX_W'($urandom_range(63));
            end else begin
                cmd = cmd_t'($urandom_range(3));
                key = (held > 0 && roll < 30)
                    ? tracker.held_date($urandom_range(held - 1)) : rand_date();
                idx = IDX_W'($urandom_range(63));
            end
            send_command(cmd, key, idx);
        end
        s_tvalid <= 1'b0;

        // wait for the last results, then a while longer for stray beats
        while (tracker.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.pending_count() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.pending_count()));

        $display("ran %0d commands: %0d inserted, %0d duplicate, %0d removed, %0d not found",
                 tracker.commands, tracker.tally[ST_INSERTED], tracker.tally[ST_DUPLICATE],
                 tracker.tally[ST_REMOVED], tracker.tally[ST_NOT_FOUND]);
        $display("  %0d empty, %0d full, %0d found, %0d read ok, %0d bad index; %0d mismatches",
                 tracker.tally[ST_EMPTY], tracker.tally[ST_FULL], tracker.tally[ST_FOUND],
                 tracker.tally[ST_READ_OK], tracker.tally[ST_BAD_INDEX], tracker.mismatches);

        if (tracker.mismatches == 0) begin
            $display("sorted_date_table regression: pass");
        end else begin
            $display("sorted_date_table regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
design/sdt_pkg.sv
design/sdt_ram.sv
design/sdt_seq.sv
design/sorted_date_table.sv
tb/sv/testbench.sv
